// File: design/f40am_pkg.sv
// Shared types, constants and helper functions for the 40-bit float add/multiply unit.
// Has no dependencies; the core module imports it.
package f40am_pkg;

  localparam int ExpW  = 11;  // signed unbiased exponent, wide enough for products
  localparam int WideW = 67;  // aligned add and normalize datapath
  localparam int LzW   = 7;   // leading-zero count over WideW bits

  typedef logic signed [ExpW-1:0] exp_t;

  typedef enum logic [1:0] {
    CmdAdd  = 2'd0,
    CmdSub  = 2'd1,
    CmdMul  = 2'd2,
    CmdSeed = 2'd3
  } cmd_t;

  localparam logic RegSingle = 1'b0;
  localparam logic RegTrunc  = 1'b1;

  // Operand with its significand left-justified (msb at bit 31) and the msb weight as x.
  typedef struct packed {
    logic        neg;
    logic        zero;
    exp_t        x;
    logic [31:0] m;
  } oper_t;

  typedef struct packed {
    logic        err;
    logic [39:0] value;
  } seed_res_t;

  localparam logic [22:0] SeedRom [128] = '{
    23'h7f8000, 23'h7e0000, 23'h7c0000, 23'h7a0000,
    23'h780000, 23'h760000, 23'h740000, 23'h720000,
    23'h700000, 23'h6f0000, 23'h6d0000, 23'h6b0000,
    23'h6a0000, 23'h680000, 23'h660000, 23'h650000,
    23'h630000, 23'h610000, 23'h600000, 23'h5e0000,
    23'h5d0000, 23'h5b0000, 23'h5a0000, 23'h590000,
    23'h570000, 23'h560000, 23'h540000, 23'h530000,
    23'h520000, 23'h500000, 23'h4f0000, 23'h4e0000,
    23'h4c0000, 23'h4b0000, 23'h4a0000, 23'h490000,
    23'h470000, 23'h460000, 23'h450000, 23'h440000,
    23'h430000, 23'h410000, 23'h400000, 23'h3f0000,
    23'h3e0000, 23'h3d0000, 23'h3c0000, 23'h3b0000,
    23'h3a0000, 23'h390000, 23'h380000, 23'h370000,
    23'h360000, 23'h350000, 23'h340000, 23'h330000,
    23'h320000, 23'h310000, 23'h300000, 23'h2f0000,
    23'h2e0000, 23'h2d0000, 23'h2c0000, 23'h2b0000,
    23'h2a0000, 23'h290000, 23'h280000, 23'h280000,
    23'h270000, 23'h260000, 23'h250000, 23'h240000,
    23'h230000, 23'h230000, 23'h220000, 23'h210000,
    23'h200000, 23'h1f0000, 23'h1f0000, 23'h1e0000,
    23'h1d0000, 23'h1c0000, 23'h1c0000, 23'h1b0000,
    23'h1a0000, 23'h190000, 23'h190000, 23'h180000,
    23'h170000, 23'h170000, 23'h160000, 23'h150000,
    23'h140000, 23'h140000, 23'h130000, 23'h120000,
    23'h120000, 23'h110000, 23'h100000, 23'h100000,
    23'h0f0000, 23'h0f0000, 23'h0e0000, 23'h0d0000,
    23'h0d0000, 23'h0c0000, 23'h0c0000, 23'h0b0000,
    23'h0a0000, 23'h0a0000, 23'h090000, 23'h090000,
    23'h080000, 23'h070000, 23'h070000, 23'h060000,
    23'h060000, 23'h050000, 23'h050000, 23'h040000,
    23'h040000, 23'h030000, 23'h030000, 23'h020000,
    23'h020000, 23'h010000, 23'h010000, 23'h000000
  };

  function automatic logic [4:0] lzc32(input logic [31:0] v);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 5'(31 - i);
    end
    return n;
  endfunction

  function automatic logic [LzW-1:0] lzc_wide(input logic [WideW-1:0] v);
    logic [LzW-1:0] n;
    n = '0;
    for (int i = 0; i < WideW; i++) begin
      if (v[i]) n = LzW'(WideW - 1 - i);
    end
    return n;
  endfunction

  // Split a raw 40-bit float; denormals are normalized here.
  function automatic oper_t unpack_op(input logic [39:0] raw);
    oper_t      o;
    logic [7:0] e;
    logic [4:0] lz;
    e = raw[38:31];
    lz = lzc32({1'b0, raw[30:0]});
    o.neg = raw[39];
    if (e != 8'd0) begin
      o.zero = 1'b0;
      o.x = exp_t'({3'b000, e}) - exp_t'(127);
      o.m = {1'b1, raw[30:0]};
    end else begin
      o.zero = (raw[30:0] == 31'd0);
      o.x = exp_t'(-126) - exp_t'({6'b000000, lz});
      o.m = {1'b0, raw[30:0]} << lz;
    end
    return o;
  endfunction

  // Round an operand to 24 significant bits when single is set.
  function automatic oper_t round_op(input oper_t o, input logic single, input logic chop);
    oper_t       r;
    logic        up;
    logic [24:0] sum;
    r = o;
    up = !chop && o.m[7] && ((|o.m[6:0]) || o.m[8]);
    sum = {1'b0, o.m[31:8]} + 25'(up);
    if (single) begin
      if (sum[24]) begin
        r.m = 32'h8000_0000;
        r.x = o.x + exp_t'(1);
      end else begin
        r.m = {sum[23:0], 8'h00};
      end
    end
    return r;
  endfunction

  function automatic seed_res_t seed_op(input logic [39:0] raw);
    seed_res_t  s;
    logic [7:0] e;
    e = raw[38:31];
    if (e == 8'd0 || e > 8'd252) begin
      s.err = 1'b1;
      s.value = {raw[39], 39'd0};
    end else begin
      s.err = 1'b0;
      s.value = {raw[39], 8'(8'd253 - e), SeedRom[raw[30:24]], 8'h00};
    end
    return s;
  endfunction

endpackage

// File: design/float40_add_mul_unit_core.sv
// Pipelined 40-bit float add / subtract / multiply / reciprocal-seed unit.
// Depends on f40am_pkg for types, the seed table and the unpack/round helpers.
//
// Usage:
//   Input beats arrive on s_tvalid/s_tready with the two operands in s_tdata and the
//   command in s_tuser. Each input beat produces exactly one output beat on
//   m_tvalid/m_tready carrying the rounded result, its chopped 32-bit store word, and
//   a range-error flag in m_tuser.
//   Mode registers (single precision, truncation) are written through the cfg channel,
//   which is always ready; write them only while no beats are in flight.
// Timing:
//   Each beat passes an input register, six work stages and an output register.
//   Throughput is one beat per cycle while the output is not stalled; the critical
//   stages are the 32x32 multiply and the 67-bit align/add and normalize shifter.
// Stall and reset:
//   The pipeline advances as a whole whenever the output register is empty or its
//   beat is taken, so s_tready drops only while m_tvalid is high and m_tready low.
//   Reset (synchronous, rst high) empties the pipeline and clears both mode bits.
module float40_add_mul_unit_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [79:0]          s_tdata,   // operand_a[39:0], operand_b[79:40]
  input  f40am_pkg::cmd_t      s_tuser,   // cmd[1:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [71:0]          m_tdata,   // result_value[39:0], store_word[71:40]
  output logic                 m_tuser,   // range_error
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic                 cfg_data
);
  import f40am_pkg::*;

  // Mode registers
  logic single_mode;
  logic trunc_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      single_mode <= 1'b0;
      trunc_mode  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegSingle: single_mode <= cfg_data;
        RegTrunc:  trunc_mode  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Whole-pipeline advance: move when the output slot is free or being drained.
  logic       adv;
  logic [7:0] vld;  // valid per stage, bit 7 is the output register

  assign adv      = !vld[7] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[6:0], s_tvalid};
    end
  end

  // Stage 1: input register
  cmd_t        s1_cmd;
  logic [39:0] s1_a;
  logic [39:0] s1_b;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd <= s_tuser;
      s1_a   <= s_tdata[39:0];
      s1_b   <= s_tdata[79:40];
    end
  end

  // Stage 2: unpack, normalize denormals, evaluate seed
  cmd_t      s2_cmd;
  oper_t     s2_a;
  oper_t     s2_b;
  seed_res_t s2_seed;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_cmd  <= s1_cmd;
      s2_a    <= unpack_op(s1_a);
      // subtract flips the sign of b, zero included
      s2_b    <= unpack_op((s1_cmd == CmdSub) ? (s1_b ^ {1'b1, 39'd0}) : s1_b);
      s2_seed <= seed_op(s1_a);
    end
  end

  // Stage 3: round operands to working precision
  cmd_t      s3_cmd;
  oper_t     s3_a;
  oper_t     s3_b;
  seed_res_t s3_seed;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_cmd  <= s2_cmd;
      s3_a    <= round_op(s2_a, single_mode, trunc_mode);
      s3_b    <= round_op(s2_b, single_mode, trunc_mode);
      s3_seed <= s2_seed;
    end
  end

  // Stage 4: multiply, or pick the larger addend and align the smaller one
  logic             a_big;
  oper_t            big_op;
  oper_t            sml_op;
  exp_t             exp_diff;
  logic [LzW-1:0]   dsh;
  logic [WideW-1:0] sml_full;
  logic [WideW-1:0] sml_mask;
  logic             sml_sticky;

  assign a_big = s3_b.zero ||
                 (!s3_a.zero && ((s3_a.x > s3_b.x) ||
                                 ((s3_a.x == s3_b.x) && (s3_a.m >= s3_b.m))));
  assign big_op   = a_big ? s3_a : s3_b;
  assign sml_op   = a_big ? s3_b : s3_a;
  assign exp_diff = big_op.x - sml_op.x;
  assign dsh      = (exp_diff > exp_t'(WideW - 1)) ? LzW'(WideW) : exp_diff[LzW-1:0];
  assign sml_full = {1'b0, sml_op.m, 34'd0};
  assign sml_mask = ~({WideW{1'b1}} << dsh);
  assign sml_sticky = |(sml_full & sml_mask);

  logic             s4_mul;
  logic             s4_seed_sel;
  seed_res_t        s4_seed;
  logic [WideW-1:0] s4_lm;
  logic [WideW-1:0] s4_sm;
  logic             s4_sub;
  logic             s4_big_neg;
  exp_t             s4_big_x;
  logic [63:0]      s4_prod;
  exp_t             s4_prod_x;
  logic             s4_prod_neg;
  logic             s4_zsign;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_mul      <= (s3_cmd == CmdMul);
      s4_seed_sel <= (s3_cmd == CmdSeed);
      s4_seed     <= s3_seed;
      s4_lm       <= big_op.zero ? '0 : {1'b0, big_op.m, 34'd0};
      s4_sm       <= sml_op.zero ? '0 :
                     ((sml_full >> dsh) | {{(WideW - 1){1'b0}}, sml_sticky});
      s4_sub      <= s3_a.neg ^ s3_b.neg;
      s4_big_neg  <= big_op.neg;
      s4_big_x    <= big_op.x;
      s4_prod     <= s3_a.m * s3_b.m;
      s4_prod_x   <= s3_a.x + s3_b.x;
      s4_prod_neg <= s3_a.neg ^ s3_b.neg;
      // sign of a zero result: xor for products, both-negative for sums
      s4_zsign    <= (s3_cmd == CmdMul) ? (s3_a.neg ^ s3_b.neg) : (s3_a.neg & s3_b.neg);
    end
  end

  // Stage 5: add or subtract; merge with the product (value = r * 2^(e - 65))
  logic             s5_seed_sel;
  seed_res_t        s5_seed;
  logic [WideW-1:0] s5_r;
  exp_t             s5_e;
  logic             s5_neg;
  logic             s5_zsign;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_seed_sel <= s4_seed_sel;
      s5_seed     <= s4_seed;
      if (s4_mul) begin
        s5_r   <= {s4_prod, 3'b000};
        s5_e   <= s4_prod_x;
        s5_neg <= s4_prod_neg;
      end else begin
        s5_r   <= s4_sub ? (s4_lm - s4_sm) : (s4_lm + s4_sm);
        s5_e   <= s4_big_x;
        s5_neg <= s4_big_neg;
      end
      s5_zsign <= s4_zsign;
    end
  end

  // Stage 6: leading-zero count
  logic             s6_seed_sel;
  seed_res_t        s6_seed;
  logic [WideW-1:0] s6_r;
  logic [LzW-1:0]   s6_lz;
  logic             s6_zero;
  exp_t             s6_e;
  logic             s6_neg;
  logic             s6_zsign;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_seed_sel <= s5_seed_sel;
      s6_seed     <= s5_seed;
      s6_r        <= s5_r;
      s6_lz       <= lzc_wide(s5_r);
      s6_zero     <= (s5_r == '0);
      s6_e        <= s5_e;
      s6_neg      <= s5_neg;
      s6_zsign    <= s5_zsign;
    end
  end

  // Stage 7: normalize so the msb sits at the top bit
  logic             s7_seed_sel;
  seed_res_t        s7_seed;
  logic [WideW-1:0] s7_n;
  exp_t             s7_x;
  logic             s7_zero;
  logic             s7_neg;
  logic             s7_zsign;

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_seed_sel <= s6_seed_sel;
      s7_seed     <= s6_seed;
      s7_n        <= s6_r << s6_lz;
      s7_x        <= s6_e + exp_t'(1) - exp_t'({4'b0000, s6_lz});
      s7_zero     <= s6_zero;
      s7_neg      <= s6_neg;
      s7_zsign    <= s6_zsign;
    end
  end

  // Final round, range check and pack
  logic        up32, up24;
  logic [32:0] sum32;
  logic [24:0] sum24;
  logic        rnd_carry;
  logic [30:0] frac;
  exp_t        field;
  logic        fld_err;
  logic [39:0] res_value;
  logic        res_err;

  assign up32  = !trunc_mode && s7_n[34] && ((|s7_n[33:0]) || s7_n[35]);
  assign up24  = !trunc_mode && s7_n[42] && ((|s7_n[41:0]) || s7_n[43]);
  assign sum32 = {1'b0, s7_n[66:35]} + 33'(up32);
  assign sum24 = {1'b0, s7_n[66:43]} + 25'(up24);

  always_comb begin
    if (single_mode) begin
      rnd_carry = sum24[24];
      frac      = sum24[24] ? 31'd0 : {sum24[22:0], 8'h00};
    end else begin
      rnd_carry = sum32[32];
      frac      = sum32[32] ? 31'd0 : sum32[30:0];
    end
  end

  assign field   = s7_x + exp_t'(127) + exp_t'({10'd0, rnd_carry});
  assign fld_err = (field < exp_t'(1)) || (field > exp_t'(255));

  always_comb begin
    if (s7_seed_sel) begin
      res_value = s7_seed.value;
      res_err   = s7_seed.err;
    end else if (s7_zero) begin
      res_value = {s7_zsign, 39'd0};
      res_err   = 1'b0;
    end else if (fld_err) begin
      // drop out-of-range results to signed zero and flag them
      res_value = {s7_neg, 39'd0};
      res_err   = 1'b1;
    end else begin
      res_value = {s7_neg, field[7:0], frac};
      res_err   = 1'b0;
    end
  end

  // Output register
  logic [39:0] out_value;
  logic        out_err;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_value <= res_value;
      out_err   <= res_err;
    end
  end

  assign m_tdata = {out_value[39:8], out_value};
  assign m_tuser = out_err;

endmodule
